FILE: rtl/two_tube_waveguide_macros.svh
// Assertion macros for the two-tube waveguide checker.
`ifndef TWO_TUBE_WAVEGUIDE_MACROS_SVH
`define TWO_TUBE_WAVEGUIDE_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define TTW_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that is also checked during reset.
`define TTW_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

FILE: rtl/ttw_pkg.sv
// Package with the types, constants and register codes of the two-tube waveguide.
`default_nettype none

package ttw_pkg;

   localparam int MAX_DELAY   = 64;
   localparam int STATE_BITS  = 24;
   localparam int FRAC_BITS   = 20;
   localparam int SAMPLE_BITS = 16;
   localparam int COEFF_BITS  = 16;
   localparam int LEN_BITS    = 7;

   localparam int ADDR_BITS    = $clog2(MAX_DELAY);
   localparam int POS_CNT_BITS = ADDR_BITS + 1;
   localparam int SAMPLE_SHIFT = FRAC_BITS - (SAMPLE_BITS - 1);

   localparam int SUM_BITS   = STATE_BITS + 1;
   localparam int LOSS_BITS  = COEFF_BITS + 1;
   localparam int LPROD_BITS = SUM_BITS + LOSS_BITS;
   localparam int KPROD_BITS = SUM_BITS + COEFF_BITS;
   localparam int WIDE_BITS  = STATE_BITS + 18;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   localparam logic signed [COEFF_BITS-1:0] SCATTER_RESET = 16'sd29491;
   localparam logic [COEFF_BITS-1:0]        LOSS_RESET    = 16'd29491;
   localparam logic [LEN_BITS-1:0]          TUBE1_RESET   = 7'd3;
   localparam logic [LEN_BITS-1:0]          TUBE2_RESET   = 7'd4;

   typedef enum logic [1:0] {
      CSR_SCATTER,
      CSR_LOSS,
      CSR_TUBE1_LEN,
      CSR_TUBE2_LEN
   } ttw_csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          end_of_block;
   } ttw_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          block_done;
   } ttw_rsp_type;

   typedef struct packed {
      logic signed [COEFF_BITS-1:0] scatter_coeff;
      logic [COEFF_BITS-1:0]        loss_gain;
      logic [LEN_BITS-1:0]          tube1_length;
      logic [LEN_BITS-1:0]          tube2_length;
   } ttw_cfg_type;

   typedef struct packed {
      logic signed [STATE_BITS-1:0] fwd;
      logic signed [STATE_BITS-1:0] bwd;
   } ttw_pair_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] addr;
      ttw_pair_type         data;
   } ttw_tube_wr_type;

endpackage

`default_nettype wire

FILE: rtl/two_tube_waveguide.sv
// Top level of the two-tube waveguide: item pipeline, tubes, datapath and registers.
// The block accepts one item in every clock cycle unless the result side stalls; each item passes
// through the stage-one register into the result register. At acceptance each tube's RAM is read at
// the tube's position; in the next cycle the datapath computes the result and the new line values,
// which are written back as the item moves into the result register, with a bypass when the following
// item reads the same entry. That single read and write per RAM per item sets the rate of one item per
// cycle while no stall holds. The delay lines start cleared through per-entry valid bits, so the block
// is ready right after reset. Registers sit at byte addresses 0, 4, 8 and 12: scattering coefficient,
// loss gain, tube one length and tube two length.
`default_nettype none

module two_tube_waveguide import ttw_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire ttw_req_type              req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output ttw_rsp_type                   rsp_data,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   ttw_cfg_type                  cfg;
   logic                         req_fire;
   logic                         s1_fire;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   ttw_req_type                  s1_req_ff;
   logic [ADDR_BITS-1:0]         s1_pos1_ff;
   logic [ADDR_BITS-1:0]         s1_pos2_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ttw_rsp_type                  rsp_data_ff;
   logic signed [STATE_BITS-1:0] end1_prev_ff;
   logic signed [STATE_BITS-1:0] end2_prev_ff;
   logic [ADDR_BITS-1:0]         pos1;
   logic [ADDR_BITS-1:0]         pos2;
   ttw_pair_type                 tube1_rd;
   ttw_pair_type                 tube2_rd;
   ttw_pair_type                 tube1_new;
   ttw_pair_type                 tube2_new;
   ttw_tube_wr_type              tube1_wr;
   ttw_tube_wr_type              tube2_wr;
   ttw_rsp_type                  core_rsp;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         end1_prev_ff <= '0;
         end2_prev_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            end1_prev_ff <= tube1_rd.bwd;
            end2_prev_ff <= tube2_rd.fwd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff  <= req_data;
         s1_pos1_ff <= pos1;
         s1_pos2_ff <= pos2;
      end
      if (s1_fire) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign tube1_wr.we   = s1_fire;
   assign tube1_wr.addr = s1_pos1_ff;
   assign tube1_wr.data = tube1_new;
   assign tube2_wr.we   = s1_fire;
   assign tube2_wr.addr = s1_pos2_ff;
   assign tube2_wr.data = tube2_new;

   ttw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ttw_tube u_tube1 (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .length  (cfg.tube1_length),
      .wr      (tube1_wr),
      .rd_pos  (pos1),
      .rd_data (tube1_rd)
   );

   ttw_tube u_tube2 (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .length  (cfg.tube2_length),
      .wr      (tube2_wr),
      .rd_pos  (pos2),
      .rd_data (tube2_rd)
   );

   ttw_core u_core (
      .cfg       (cfg),
      .req       (s1_req_ff),
      .tube1     (tube1_rd),
      .tube2     (tube2_rd),
      .end1_prev (end1_prev_ff),
      .end2_prev (end2_prev_ff),
      .rsp       (core_rsp),
      .tube1_wr  (tube1_new),
      .tube2_wr  (tube2_new)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ttw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ttw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ttw_csr.sv
// APB-style configuration registers of the two-tube waveguide.
`default_nettype none

module ttw_csr import ttw_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready,
   output ttw_cfg_type                   cfg
);

   ttw_cfg_type       cfg_ff;
   ttw_csr_index_type index;
   logic              write;

   assign index  = ttw_csr_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign write  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scatter_coeff <= SCATTER_RESET;
         cfg_ff.loss_gain     <= LOSS_RESET;
         cfg_ff.tube1_length  <= TUBE1_RESET;
         cfg_ff.tube2_length  <= TUBE2_RESET;
      end else if (write) begin
         unique case (index)
            CSR_SCATTER:   cfg_ff.scatter_coeff <= pwdata[COEFF_BITS-1:0];
            CSR_LOSS:      cfg_ff.loss_gain     <= pwdata[COEFF_BITS-1:0];
            CSR_TUBE1_LEN: cfg_ff.tube1_length  <= pwdata[LEN_BITS-1:0];
            CSR_TUBE2_LEN: cfg_ff.tube2_length  <= pwdata[LEN_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_SCATTER:   prdata = CSR_DATA_BITS'($unsigned(cfg_ff.scatter_coeff));
         CSR_LOSS:      prdata = CSR_DATA_BITS'(cfg_ff.loss_gain);
         CSR_TUBE1_LEN: prdata = CSR_DATA_BITS'(cfg_ff.tube1_length);
         CSR_TUBE2_LEN: prdata = CSR_DATA_BITS'(cfg_ff.tube2_length);
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/ttw_tube.sv
// One tube: both delay lines in a RAM, entry valid bits, position and write bypass.
`default_nettype none

module ttw_tube import ttw_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [LEN_BITS-1:0] length,
   input  wire ttw_tube_wr_type     wr,
   output logic [ADDR_BITS-1:0]     rd_pos,
   output ttw_pair_type             rd_data
);

   logic [ADDR_BITS-1:0]    pos_ff;
   logic [ADDR_BITS-1:0]    pos_in;
   logic [MAX_DELAY-1:0]    valid_ff;
   logic                    bypass_ff;
   logic                    hit_ff;
   ttw_pair_type            bypass_data_ff;
   logic [2*STATE_BITS-1:0] ram_rdata;
   logic [POS_CNT_BITS-1:0] eff_len;
   logic [POS_CNT_BITS-1:0] pos_next;

   function automatic logic [POS_CNT_BITS-1:0] eff_length(input logic [LEN_BITS-1:0] len);
      int v;
      v = int'(len);
      priority if (v == 0) begin
         v = 1;
      end else if (v > MAX_DELAY) begin
         v = MAX_DELAY;
      end
      return POS_CNT_BITS'(v);
   endfunction

   assign eff_len  = eff_length(length);
   assign pos_next = POS_CNT_BITS'(pos_ff) + POS_CNT_BITS'(1);

   always_comb begin
      pos_in = pos_ff;
      if (rd_en) begin
         pos_in = (pos_next >= eff_len) ? '0 : pos_next[ADDR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         valid_ff  <= '0;
         bypass_ff <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (wr.we) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            bypass_ff <= wr.we && (wr.addr == pos_ff);
            hit_ff    <= valid_ff[pos_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bypass_data_ff <= wr.data;
      end
   end

   ttw_ram #(
      .WIDTH (2*STATE_BITS),
      .DEPTH (MAX_DELAY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.we),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   // Entries never written read as zero; a write in the read cycle is forwarded.
   always_comb begin
      priority if (bypass_ff) begin
         rd_data = bypass_data_ff;
      end else if (hit_ff) begin
         rd_data = ttw_pair_type'(ram_rdata);
      end else begin
         rd_data = '0;
      end
   end

   assign rd_pos = pos_ff;

endmodule

`default_nettype wire

FILE: rtl/ttw_core.sv
// Sample datapath: end filters, scattering junction and output conversion.
`default_nettype none

module ttw_core import ttw_pkg::*; (
   input  wire ttw_cfg_type                  cfg,
   input  wire ttw_req_type                  req,
   input  wire ttw_pair_type                 tube1,
   input  wire ttw_pair_type                 tube2,
   input  wire logic signed [STATE_BITS-1:0] end1_prev,
   input  wire logic signed [STATE_BITS-1:0] end2_prev,
   output ttw_rsp_type                       rsp,
   output ttw_pair_type                      tube1_wr,
   output ttw_pair_type                      tube2_wr
);

   localparam logic signed [WIDE_BITS-1:0] LOSS_HALF = WIDE_BITS'(32768);
   localparam logic signed [WIDE_BITS-1:0] JUNC_HALF = WIDE_BITS'(16384);

   logic signed [SUM_BITS-1:0]   sum1;
   logic signed [SUM_BITS-1:0]   sum2;
   logic signed [LOSS_BITS-1:0]  loss;
   logic signed [LPROD_BITS-1:0] lprod1;
   logic signed [LPROD_BITS-1:0] lprod2;
   logic signed [WIDE_BITS-1:0]  lround1;
   logic signed [WIDE_BITS-1:0]  lround2;
   logic signed [STATE_BITS-1:0] e1;
   logic signed [STATE_BITS-1:0] e2;
   logic signed [SUM_BITS-1:0]   diff;
   logic signed [KPROD_BITS-1:0] kprod;
   logic signed [WIDE_BITS-1:0]  kround;
   logic signed [WIDE_BITS-1:0]  excite;
   logic signed [WIDE_BITS-1:0]  out_wide;

   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [WIDE_BITS-1:0] x
   );
      logic [WIDE_BITS-STATE_BITS:0] hi_bits;
      hi_bits = x[WIDE_BITS-1:STATE_BITS-1];
      priority if (hi_bits == '0 || hi_bits == '1) begin
         return x[STATE_BITS-1:0];
      end else if (x[WIDE_BITS-1]) begin
         return {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_BITS-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [WIDE_BITS-1:0] x
   );
      logic [WIDE_BITS-SAMPLE_BITS:0] hi_bits;
      hi_bits = x[WIDE_BITS-1:SAMPLE_BITS-1];
      priority if (hi_bits == '0 || hi_bits == '1) begin
         return x[SAMPLE_BITS-1:0];
      end else if (x[WIDE_BITS-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   // Two-point averaging end filters with loss.
   assign loss    = $signed({1'b0, cfg.loss_gain});
   assign sum1    = SUM_BITS'(end1_prev) + SUM_BITS'(tube1.bwd);
   assign sum2    = SUM_BITS'(end2_prev) + SUM_BITS'(tube2.fwd);
   assign lprod1  = sum1 * loss;
   assign lprod2  = sum2 * loss;
   assign lround1 = (WIDE_BITS'(lprod1) + LOSS_HALF) >>> 16;
   assign lround2 = (WIDE_BITS'(lprod2) + LOSS_HALF) >>> 16;
   assign e1      = sat_state(lround1);
   assign e2      = sat_state(lround2);

   // The junction shares one product: both outputs are a line value plus k*(r1 - l2).
   assign diff   = SUM_BITS'(tube1.fwd) - SUM_BITS'(tube2.bwd);
   assign kprod  = diff * cfg.scatter_coeff;
   assign kround = (WIDE_BITS'(kprod) + JUNC_HALF) >>> 15;

   assign excite = WIDE_BITS'(req.sample_in) <<< SAMPLE_SHIFT;

   assign tube1_wr.fwd = sat_state(excite + WIDE_BITS'(e1));
   assign tube1_wr.bwd = sat_state(WIDE_BITS'(tube2.bwd) + kround);
   assign tube2_wr.fwd = sat_state(WIDE_BITS'(tube1.fwd) + kround);
   assign tube2_wr.bwd = e2;

   assign out_wide       = WIDE_BITS'(tube1.fwd) >>> SAMPLE_SHIFT;
   assign rsp.sample_out = sat_sample(out_wide);
   assign rsp.block_done = req.end_of_block;

endmodule

`default_nettype wire

FILE: rtl/ttw_checker.sv
// Port-level assertion checker for the two-tube waveguide, bound to the top level.
`default_nettype none

`include "two_tube_waveguide_macros.svh"

module ttw_checker import ttw_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire ttw_rsp_type rsp_data,
   input wire logic        pready
);

   `TTW_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid && !req_stall, "reset left an item in flight")
   `TTW_ASSERT(a_result_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result item changed")
   `TTW_ASSERT(a_no_false_stall, clock, reset, !rsp_stall |-> !req_stall, "input stalled while the result side was free")
   `TTW_ASSERT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid, "accepted item did not reach the result register")
   `TTW_ASSERT_ALWAYS(a_pready_high, clock, pready, "configuration port not ready")

endmodule

bind two_tube_waveguide ttw_checker u_checker (.*);

`default_nettype wire
